@@ design/arp_responder_cache_assert.svh @@
// ----------------------------------------------------------------------------
// ARP responder cache assertion macros
// Shared assertion forms for the checker of the ARP responder cache.
// ----------------------------------------------------------------------------
`ifndef ARP_RESPONDER_CACHE_ASSERT_SVH
`define ARP_RESPONDER_CACHE_ASSERT_SVH

// Clocked implication with a reset that disables the check.
`define ARPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// A stalled beat keeps its valid and its payload in the next cycle.
`define ARPC_ASSERT_HOLD(label, clk, rst, vld, rdy, pay, msg) \
   label: assert property (@(posedge clk) disable iff (rst) \
      (vld && !rdy) |=> (vld && $stable(pay))) \
      else $error(msg);

`endif

@@ design/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP responder cache package
// Opcodes, register indexes and the command passed from front to back.
// ----------------------------------------------------------------------------
package arpc_pkg;

   localparam logic [15:0] OPC_REQUEST = 16'h0100;
   localparam logic [15:0] OPC_REPLY   = 16'h0200;

   localparam logic CSR_OWN_IP = 1'b0;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_LOOKUP,
      CMD_LEARN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         send_reply;
      logic [31:0]  key_ip;
      logic [47:0]  mac;
   } cmd_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SCAN,
      B_WRITE,
      B_RESULT
   } back_state_type;

endpackage

@@ design/arpc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/arpc_fifo.sv @@
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module arpc_fifo #(
   parameter int WIDTH = 82,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/arpc_front.sv @@
// ----------------------------------------------------------------------------
// ARP responder cache front end
// Holds the station address, accepts beats and turns each into a command.
// ----------------------------------------------------------------------------
module arpc_front
   import arpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [31:0]  csr_ip,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic         req_tuser,
   input  logic         queue_full,
   output logic         push,
   output cmd_type      push_cmd
);

   logic [31:0] own_ip_ff, own_ip_in;
   logic [15:0] opcode;
   logic [31:0] sender_ip;
   logic [47:0] sender_mac;
   logic [31:0] target_ip;
   logic        for_us;

   assign opcode     = req_tdata[15:0];
   assign sender_ip  = req_tdata[47:16];
   assign sender_mac = req_tdata[95:48];
   assign target_ip  = req_tdata[127:96];

   assign own_ip_in  = (csr_we && csr_addr == CSR_OWN_IP) ? csr_ip : own_ip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= '0;
      end else begin
         own_ip_ff <= own_ip_in;
      end
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;
   assign for_us     = (target_ip == own_ip_ff);

   always_comb begin
      push_cmd.kind       = CMD_NONE;
      push_cmd.send_reply = 1'b0;
      push_cmd.key_ip     = req_tuser ? target_ip : sender_ip;
      push_cmd.mac        = sender_mac;
      if (req_tuser) begin
         if (target_ip != '0) begin
            push_cmd.kind = CMD_LOOKUP;
         end
      end else if (for_us && (opcode == OPC_REQUEST || opcode == OPC_REPLY)) begin
         push_cmd.send_reply = (opcode == OPC_REQUEST);
         if (sender_ip != '0) begin
            push_cmd.kind = CMD_LEARN;
         end
      end
   end

endmodule

@@ design/arpc_back.sv @@
// ----------------------------------------------------------------------------
// ARP responder cache back end
// Scans the address table one entry per cycle, learns senders, answers
// lookups and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module arpc_back
   import arpc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         queue_empty,
   input  cmd_type      head_cmd,
   output logic         pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,
   output logic [1:0]   rsp_tuser
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   back_state_type           state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [CW-1:0]            issue_cnt_ff, issue_cnt_in;
   logic                     pend_ff, pend_in;
   logic [AW-1:0]            pend_idx_ff, pend_idx_in;
   logic                     free_found_ff, free_found_in;
   logic [AW-1:0]            free_idx_ff, free_idx_in;
   logic                     hit_ff, hit_in;
   logic [47:0]              mac_ff, mac_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [127:0]             rsp_data_ff, rsp_data_in;
   logic [1:0]               rsp_user_ff, rsp_user_in;

   logic                     ram_we;
   logic [AW-1:0]            ram_raddr;
   logic [79:0]              ram_rdata;
   logic                     issue_more;
   logic                     entry_valid;
   logic                     match;
   logic                     last;
   logic                     out_free;
   logic                     is_lookup;

   arpc_ram #(
      .WIDTH (80),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (free_idx_ff),
      .wdata ({cmd_ff.mac, cmd_ff.key_ip}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign issue_more  = (issue_cnt_ff != CW'(TABLE_ENTRIES));
   assign ram_raddr   = issue_cnt_ff[AW-1:0];
   assign entry_valid = valid_ff[pend_idx_ff];
   assign match       = pend_ff && entry_valid && (ram_rdata[31:0] == cmd_ff.key_ip);
   assign last        = pend_ff && (pend_idx_ff == AW'(TABLE_ENTRIES - 1));
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign is_lookup   = (cmd_ff.kind == CMD_LOOKUP);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               state_in = (head_cmd.kind == CMD_NONE) ? B_RESULT : B_SCAN;
            end
         end
         B_SCAN: begin
            if (match) begin
               state_in = B_RESULT;
            end else if (last) begin
               if (cmd_ff.kind == CMD_LEARN && (free_found_ff || !entry_valid)) begin
                  state_in = B_WRITE;
               end else begin
                  state_in = B_RESULT;
               end
            end
         end
         B_WRITE: begin
            state_in = B_RESULT;
         end
         B_RESULT: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      pop           = 1'b0;
      ram_we        = 1'b0;
      cmd_in        = cmd_ff;
      issue_cnt_in  = issue_cnt_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_in        = hit_ff;
      mac_in        = mac_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      case (state_ff)
         B_IDLE: begin
            pop           = !queue_empty;
            cmd_in        = head_cmd;
            issue_cnt_in  = '0;
            free_found_in = 1'b0;
            hit_in        = 1'b0;
            mac_in        = '0;
         end
         B_SCAN: begin
            if (issue_more) begin
               pend_in      = 1'b1;
               pend_idx_in  = issue_cnt_ff[AW-1:0];
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (match) begin
               hit_in = 1'b1;
               mac_in = ram_rdata[79:32];
            end else if (pend_ff && !entry_valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = pend_idx_ff;
            end
         end
         B_WRITE: begin
            ram_we                = 1'b1;
            valid_in[free_idx_ff] = 1'b1;
         end
         B_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = {is_lookup && hit_ff, cmd_ff.send_reply};
               rsp_data_in  = {(is_lookup && hit_ff) ? mac_ff : 48'd0,
                               cmd_ff.send_reply ? cmd_ff.key_ip : 32'd0,
                               cmd_ff.send_reply ? cmd_ff.mac : 48'd0};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      issue_cnt_ff  <= issue_cnt_in;
      pend_idx_ff   <= pend_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hit_ff        <= hit_in;
      mac_ff        <= mac_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ design/arp_responder_cache.sv @@
// ----------------------------------------------------------------------------
// ARP responder cache
// Answers ARP requests for this station and caches sender addresses.
// ----------------------------------------------------------------------------
// Each beat is either an ARP packet summary or an address lookup. The front
// end classifies it against own_ip and queues a command; the back end walks
// the address table through a RAM read port, one entry per cycle. A lookup
// or a learning packet passes the scan and result states of the back end
// (and a write state when a new sender is written), a beat that needs no
// table walk goes straight to result, one command at a time. The queue lets
// QUEUE_DEPTH further beats be accepted while the back end works. The own_mac
// register is accepted on the write port but feeds no result field.
module arp_responder_cache
   import arpc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 8,
   parameter int QUEUE_DEPTH   = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [47:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode, sender_ip, sender_mac, target_ip
   input  logic [127:0] req_tdata,
   // op
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // reply_mac, reply_ip, found_mac
   output logic [127:0] rsp_tdata,
   // send_reply, hit
   output logic [1:0]   rsp_tuser
);

   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_empty;
   cmd_type push_cmd;
   cmd_type head_cmd;

   arpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_ip     (csr_wdata[31:0]),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   arpc_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .head_data (head_cmd),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   arpc_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

@@ design/arpc_checker.sv @@
// ----------------------------------------------------------------------------
// ARP responder cache checker
// Watches the result port of the top level over time.
// ----------------------------------------------------------------------------
`include "arp_responder_cache_assert.svh"

module arpc_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   `ARPC_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_tvalid, rsp_tready, {rsp_tuser, rsp_tdata}, "Stalled result beat changed.")
   `ARPC_ASSERT(a_reply_zero, clock, reset, (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[79:0] == '0), "Reply fields set without a reply.")
   `ARPC_ASSERT(a_found_zero, clock, reset, (rsp_tvalid && !rsp_tuser[1]) |-> (rsp_tdata[127:80] == '0), "Found MAC set without a hit.")
   `ARPC_ASSERT(a_kind_excl, clock, reset, rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]), "Reply and hit in one beat.")

endmodule

bind arp_responder_cache arpc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ dv/arpc_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP responder cache verification package
// Beat kinds shared by the stimulus and the checker, and the own_mac register index.
// ----------------------------------------------------------------------------
package arpc_tb_pkg;

   typedef enum logic {
      BEAT_PACKET = 1'b0,
      BEAT_LOOKUP = 1'b1
   } beat_kind_type;

   localparam logic CSR_OWN_MAC = 1'b1;

endpackage

@@ dv/arp_responder_cache_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP responder cache checker
// Watches the register port and both streams, keeps its own copy of the
// station address and the address table, predicts the answer to every
// accepted request beat and compares each response beat field by field.
// ----------------------------------------------------------------------------
module arp_responder_cache_checker
   import arpc_pkg::*;
   import arpc_tb_pkg::*;
#(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [47:0]  csr_wdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   output int unsigned  pending_count,
   output int unsigned  error_count
);

   typedef struct packed {
      logic        send_reply;
      logic [47:0] reply_mac;
      logic [31:0] reply_ip;
      logic        hit;
      logic [47:0] found_mac;
   } arp_answer_type;

   logic [31:0]    station_ip;
   logic [31:0]    cache_ip [TABLE_ENTRIES];
   logic [47:0]    cache_mac [TABLE_ENTRIES];
   arp_answer_type answer_queue [$];
   arp_answer_type wanted;
   int unsigned    mismatches = 0;

   function automatic void learn_sender(input logic [31:0] ip, input logic [47:0] mac);
      if (ip == '0) return;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         if (cache_ip[k] == ip) return;
      end
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         if (cache_ip[k] == '0) begin
            cache_ip[k] = ip;
            cache_mac[k] = mac;
            return;
         end
      end
   endfunction

   function automatic arp_answer_type resolve_beat(input beat_kind_type kind,
                                                   input logic [127:0] data);
      logic [15:0]    opcode;
      logic [31:0]    sender_ip;
      logic [47:0]    sender_mac;
      logic [31:0]    target_ip;
      arp_answer_type answer;
      opcode = data[15:0];
      sender_ip = data[47:16];
      sender_mac = data[95:48];
      target_ip = data[127:96];
      answer = '0;
      if (kind == BEAT_LOOKUP) begin
         if (target_ip != '0) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
               if (cache_ip[k] == target_ip) begin
                  answer.hit = 1'b1;
                  answer.found_mac = cache_mac[k];
                  break;
               end
            end
         end
      end else if (target_ip == station_ip) begin
         if (opcode == OPC_REQUEST) begin
            learn_sender(sender_ip, sender_mac);
            answer.send_reply = 1'b1;
            answer.reply_mac = sender_mac;
            answer.reply_ip = sender_ip;
         end else if (opcode == OPC_REPLY) begin
            learn_sender(sender_ip, sender_mac);
         end
      end
      return answer;
   endfunction

   task automatic check_field(input string name, input logic [47:0] expected,
                              input logic [47:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         station_ip = '0;
         for (int k = 0; k < TABLE_ENTRIES; k++) begin
            cache_ip[k] = '0;
            cache_mac[k] = '0;
         end
         answer_queue.delete();
      end else begin
         if (csr_we && csr_addr == CSR_OWN_IP) begin
            station_ip = csr_wdata[31:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (answer_queue.size() == 0) begin
               $error("response beat arrived with no answer outstanding");
               mismatches++;
            end else begin
               wanted = answer_queue.pop_front();
               check_field("send_reply", 48'(wanted.send_reply), 48'(rsp_tuser[0]));
               check_field("reply_mac", wanted.reply_mac, rsp_tdata[47:0]);
               check_field("reply_ip", 48'(wanted.reply_ip), 48'(rsp_tdata[79:48]));
               check_field("hit", 48'(wanted.hit), 48'(rsp_tuser[1]));
               check_field("found_mac", wanted.found_mac, rsp_tdata[127:80]);
            end
         end
         if (req_tvalid && req_tready) begin
            answer_queue.push_back(resolve_beat(beat_kind_type'(req_tuser), req_tdata));
         end
      end
      pending_count <= answer_queue.size();
      error_count <= mismatches;
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP responder cache testbench
// Drives a directed run through the table corner cases, then random phases
// of ARP packets and lookups under several station addresses, with random
// gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_top;
   import arpc_pkg::*;
   import arpc_tb_pkg::*;

   localparam int TABLE_ENTRIES = 8;
   localparam int PHASE_BEATS   = 340;
   localparam int PHASES        = 5;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         csr_we     = 1'b0;
   logic         csr_addr   = CSR_OWN_IP;
   logic [47:0]  csr_wdata  = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata  = '0;
   logic         req_tuser  = BEAT_PACKET;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   int unsigned  pending_count;
   int unsigned  error_count;

   logic [31:0]  station_ip = '0;
   bit           steady_send = 1'b0;
   int           ready_hold = 0;
   logic [31:0]  known_ip [12] = '{
      32'h0A000001, 32'h0A000002, 32'hFFFFFFFF, 32'h0A000004,
      32'h0A000005, 32'h0A000006, 32'h0A000007, 32'h0A000008,
      32'h0A000009, 32'h0A00000A, 32'hC0A80002, 32'h00000001
   };

   arp_responder_cache #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   arp_responder_cache_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 9) < 7) begin
         rsp_tready <= 1'b1;
         ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b0;
         ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(0, 3);
      end
   end

   function automatic logic [127:0] arp_fields(input logic [15:0] opcode,
                                                input logic [31:0] sender_ip,
                                                input logic [47:0] sender_mac,
                                                input logic [31:0] target_ip);
      return {target_ip, sender_mac, sender_ip, opcode};
   endfunction

   function automatic int next_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_send || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_beat(input beat_kind_type kind, input logic [127:0] data);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic set_station(input logic [31:0] ip, input logic [47:0] mac);
      drain();
      csr_we <= 1'b1;
      csr_addr <= CSR_OWN_IP;
      csr_wdata <= {16'h0000, ip};
      @(posedge clock);
      csr_addr <= CSR_OWN_MAC;
      csr_wdata <= mac;
      @(posedge clock);
      csr_we <= 1'b0;
      station_ip = ip;
      @(posedge clock);
   endtask

   task automatic run_directed();
      send_beat(BEAT_LOOKUP, arp_fields(16'hFFFF, '1, '1, known_ip[0]));
      send_beat(BEAT_LOOKUP, arp_fields('0, '0, '0, '0));
      send_beat(BEAT_PACKET, arp_fields(OPC_REQUEST, known_ip[0], 48'h020000000A01,
                                        station_ip));
      send_beat(BEAT_PACKET, arp_fields(OPC_REPLY, known_ip[1], 48'h020000000A02,
                                        station_ip));
      send_beat(BEAT_PACKET, arp_fields(OPC_REQUEST, known_ip[0], 48'h0ABCDEF01234,
                                        station_ip));
      send_beat(BEAT_LOOKUP, arp_fields('0, '0, '0, known_ip[0]));
      send_beat(BEAT_PACKET, arp_fields(OPC_REQUEST, '0, 48'h02000000FFFE, station_ip));
      send_beat(BEAT_LOOKUP, arp_fields('0, '0, '0, '0));
      send_beat(BEAT_PACKET, arp_fields(OPC_REQUEST, known_ip[9], 48'h020000000A0A,
                                        known_ip[10]));
      send_beat(BEAT_PACKET, arp_fields(16'h0001, known_ip[9], 48'h020000000A0A,
                                        station_ip));
      send_beat(BEAT_PACKET, arp_fields(16'hFFFF, known_ip[9], 48'h020000000A0A,
                                        station_ip));
      send_beat(BEAT_PACKET, arp_fields(OPC_REQUEST, known_ip[2], '1, station_ip));
      for (int k = 3; k < TABLE_ENTRIES; k++) begin
         send_beat(BEAT_PACKET, arp_fields((k % 2 == 0) ? OPC_REPLY : OPC_REQUEST,
                                           known_ip[k], 48'h020000000A00 + k, station_ip));
      end
      send_beat(BEAT_PACKET, arp_fields(OPC_REQUEST, known_ip[8], 48'h020000000A09,
                                        station_ip));
      send_beat(BEAT_LOOKUP, arp_fields('0, '0, '0, known_ip[8]));
      send_beat(BEAT_LOOKUP, arp_fields('0, '0, '0, known_ip[2]));
      send_beat(BEAT_LOOKUP, arp_fields('0, '0, '0, known_ip[9]));
      send_beat(BEAT_LOOKUP, arp_fields('0, '0, '0, known_ip[7]));
   endtask

   task automatic send_random_beat();
      int          roll;
      logic [15:0] opcode;
      logic [31:0] sender_ip;
      logic [47:0] sender_mac;
      logic [31:0] target_ip;
      opcode = 16'($urandom);
      sender_mac[47:32] = 16'($urandom);
      sender_mac[31:0] = $urandom;
      roll = $urandom_range(0, 9);
      if (roll < 5) sender_ip = known_ip[$urandom_range(0, 11)];
      else if (roll == 5) sender_ip = '0;
      else sender_ip = $urandom;
      roll = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < 40) begin
         if (roll < 6) target_ip = known_ip[$urandom_range(0, 11)];
         else if (roll == 6) target_ip = '0;
         else target_ip = $urandom;
         send_beat(BEAT_LOOKUP, arp_fields(opcode, sender_ip, sender_mac, target_ip));
      end else begin
         if (roll < 8) target_ip = station_ip;
         else if (roll == 8) target_ip = known_ip[$urandom_range(0, 11)];
         else target_ip = $urandom;
         roll = $urandom_range(0, 99);
         if (roll < 45) opcode = OPC_REQUEST;
         else if (roll < 80) opcode = OPC_REPLY;
         send_beat(BEAT_PACKET, arp_fields(opcode, sender_ip, sender_mac, target_ip));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_station(32'hC0A80001, 48'h020000000001);
      run_directed();
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: set_station('0, '0);
            1: set_station('1, '1);
            default: set_station($urandom, {16'($urandom), 32'($urandom)});
         endcase
         for (int i = 0; i < PHASE_BEATS; i++) begin
            if (i % 60 == 0) steady_send = ($urandom_range(0, 3) == 0);
            send_random_beat();
         end
      end
      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #1_500_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/arpc_pkg.sv
design/arpc_ram.sv
design/arpc_fifo.sv
design/arpc_front.sv
design/arpc_back.sv
design/arp_responder_cache.sv
design/arpc_checker.sv
dv/arpc_tb_pkg.sv
dv/arp_responder_cache_checker.sv
dv/tb_top.sv
